// File: rtl/pnei_pkg.sv
// pnei_pkg: shared types, widths and arithmetic helpers for the point normal edge block
// used by every rtl file of the block; depends on nothing
`default_nettype none
package pnei_pkg;

   localparam int unsigned PT_W    = 32;
   localparam int unsigned NRM_W   = 16;
   localparam int unsigned A_W     = 17;
   localparam int unsigned MAG_W   = 17;
   localparam int unsigned SQ_W    = 34;
   localparam int unsigned X_W     = 50;
   localparam int unsigned ROOT_W  = 25;
   localparam int unsigned REM_W   = 27;
   localparam int unsigned Q_W     = 15;
   localparam int unsigned NUM_W   = 41;
   localparam int unsigned DIV_W   = 26;
   localparam int unsigned PROD_W  = 32;
   localparam int unsigned WZ_W    = 53;
   localparam int unsigned ACC_W   = 54;
   localparam int unsigned W_W     = 20;
   localparam int unsigned INFO_W  = 32;
   localparam int unsigned MIDQ_DEPTH = 4;
   localparam int unsigned OUTQ_DEPTH = 2;

   localparam logic [W_W-1:0] NORMAL_WEIGHT_RESET = 20'd100000;
   localparam logic [INFO_W-1:0] INFO_ONE = 32'd1024;

   typedef struct packed {
      logic signed [31:0] first_point_x;
      logic signed [31:0] first_point_y;
      logic signed [31:0] first_point_z;
      logic signed [15:0] first_normal_x;
      logic signed [15:0] first_normal_y;
      logic signed [15:0] first_normal_z;
      logic signed [31:0] second_point_x;
      logic signed [31:0] second_point_y;
      logic signed [31:0] second_point_z;
      logic signed [15:0] second_normal_x;
      logic signed [15:0] second_normal_y;
      logic signed [15:0] second_normal_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] error_x;
      logic signed [31:0] error_y;
      logic signed [31:0] error_z;
      logic signed [31:0] info_xx;
      logic signed [31:0] info_xy;
      logic signed [31:0] info_xz;
      logic signed [31:0] info_yy;
      logic signed [31:0] info_yz;
      logic signed [31:0] info_zz;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][PT_W-1:0] err;
      logic [2:0][A_W-1:0]  sum;
      logic                 degen;
   } mid_type;

   typedef struct packed {
      logic [2:0][PT_W-1:0]  err;
      logic                  degen;
      logic [2:0][NRM_W-1:0] n;
      logic [2:0][NRM_W-1:0] u;
   } side_type;

   typedef struct packed {
      logic                  valid;
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [2:0][SQ_W-1:0]  sq;
      side_type              side;
   } sq_stage_type;

   typedef struct packed {
      logic                  valid;
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [X_W-1:0]        x;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
      side_type              side;
   } rt_stage_type;

   typedef struct packed {
      logic                  valid;
      logic [2:0]            neg;
      logic [2:0][NUM_W-1:0] num;
      logic [2:0][Q_W-1:0]   q;
      logic [DIV_W-1:0]      d;
      logic                  zero;
      side_type              side;
   } dv_stage_type;

   typedef struct packed {
      logic                valid;
      logic [2:0][A_W-1:0] a;
      side_type            side;
   } a_stage_type;

   typedef struct packed {
      logic                   valid;
      logic [5:0][PROD_W-1:0] p;
      side_type               side;
   } cp_stage_type;

   typedef struct packed {
      logic                        valid;
      logic [5:0][2:0][PROD_W-1:0] p;
      logic [2:0][PT_W-1:0]        err;
      logic                        degen;
   } p1_stage_type;

   typedef struct packed {
      logic                    valid;
      logic [5:0][PROD_W:0]    sxy;
      logic [5:0][WZ_W-1:0]    wz;
      logic [2:0][PT_W-1:0]    err;
      logic                    degen;
   } p2_stage_type;

   typedef struct packed {
      logic                  valid;
      logic [5:0][ACC_W-1:0] acc;
      logic [2:0][PT_W-1:0]  err;
      logic                  degen;
   } p3_stage_type;

   function automatic logic [MAG_W-1:0] mag_a(input logic signed [A_W-1:0] a);
      return a[A_W-1] ? MAG_W'(-a) : MAG_W'(a);
   endfunction

   function automatic logic [NRM_W-1:0] mag_n(input logic signed [NRM_W-1:0] a);
      return a[NRM_W-1] ? NRM_W'(-a) : NRM_W'(a);
   endfunction

   function automatic logic [PT_W-1:0] sat32(input logic signed [PT_W:0] x);
      logic [PT_W-1:0] r;
      if (x > 33'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (x < -33'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[PT_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [A_W-1:0] rnd14(input logic signed [PROD_W-1:0] a,
                                            input logic signed [PROD_W-1:0] b);
      logic signed [PROD_W:0] d;
      logic [PROD_W:0]        m;
      logic [PROD_W:0]        r;
      d = (PROD_W+1)'(a) - (PROD_W+1)'(b);
      m = d[PROD_W] ? (PROD_W+1)'(-d) : (PROD_W+1)'(d);
      r = (m + (PROD_W+1)'(1 << 13)) >> 14;
      return d[PROD_W] ? A_W'(-r) : A_W'(r);
   endfunction

   function automatic logic [INFO_W-1:0] info_round(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-1:0]        m;
      logic [ACC_W-1:0]        r;
      logic signed [PT_W:0]    s;
      m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
      r = (m + ACC_W'(1 << 17)) >> 18;
      if (r > ACC_W'(33'd2147483648)) begin
         s = x[ACC_W-1] ? -33'sd2147483649 : 33'sd2147483648;
      end else begin
         s = x[ACC_W-1] ? -$signed((PT_W+1)'(r)) : $signed((PT_W+1)'(r));
      end
      return sat32(s);
   endfunction

endpackage
`default_nettype wire

// File: rtl/pnei_front.sv
// pnei_front: accepts request beats, forms the saturated error and normal sum, queues them
// depends on pnei_pkg
`default_nettype none
module pnei_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  pnei_pkg::req_type req_data,
   output logic              mid_valid,
   input  logic              mid_pop,
   output pnei_pkg::mid_type mid_data
);
   import pnei_pkg::*;

   localparam int unsigned AW = $clog2(MIDQ_DEPTH);
   localparam int unsigned CW = $clog2(MIDQ_DEPTH + 1);

   mid_type        q_ff [MIDQ_DEPTH];
   logic [AW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   mid_type        item;
   logic           push;
   logic           pop;

   always_comb begin
      item.err[0] = sat32((PT_W+1)'(req_data.first_point_x) - (PT_W+1)'(req_data.second_point_x));
      item.err[1] = sat32((PT_W+1)'(req_data.first_point_y) - (PT_W+1)'(req_data.second_point_y));
      item.err[2] = sat32((PT_W+1)'(req_data.first_point_z) - (PT_W+1)'(req_data.second_point_z));
      item.sum[0] = A_W'(req_data.first_normal_x) + A_W'(req_data.second_normal_x);
      item.sum[1] = A_W'(req_data.first_normal_y) + A_W'(req_data.second_normal_y);
      item.sum[2] = A_W'(req_data.first_normal_z) + A_W'(req_data.second_normal_z);
      item.degen  = (item.sum[0] == '0) && (item.sum[1] == '0) && (item.sum[2] == '0);
   end

   assign req_full  = (count_ff == CW'(MIDQ_DEPTH));
   assign mid_valid = (count_ff != '0);
   assign mid_data  = q_ff[head_ff];
   assign push      = req_push && !req_full;
   assign pop       = mid_pop && mid_valid;

   always_comb begin
      head_in  = pop ? head_ff + AW'(1) : head_ff;
      tail_in  = push ? tail_ff + AW'(1) : tail_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= item;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pnei_norm.sv
// pnei_norm: pipelined vector normalize, square sum, digit-by-digit root, restoring divide
// depends on pnei_pkg
`default_nettype none
module pnei_norm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [2:0][pnei_pkg::A_W-1:0]     in_a,
   input  pnei_pkg::side_type                in_side,
   output logic                              out_valid,
   output logic [2:0][pnei_pkg::NRM_W-1:0]   out_o,
   output pnei_pkg::side_type                out_side
);
   import pnei_pkg::*;

   sq_stage_type          sq_ff, sq_in;
   rt_stage_type          rt_ff [ROOT_W+1];
   rt_stage_type          rt_in [ROOT_W+1];
   dv_stage_type          dv_ff [Q_W+1];
   dv_stage_type          dv_in [Q_W+1];
   logic                  out_valid_ff;
   logic [2:0][NRM_W-1:0] out_o_ff, out_o_in;
   side_type              out_side_ff;

   always_comb begin
      logic [REM_W-1:0]  remn;
      logic [REM_W-1:0]  test;
      logic [NUM_W-1:0]  dsh;
      logic [ROOT_W-1:0] len;
      logic [Q_W-1:0]    qv;

      sq_in.valid = in_valid;
      sq_in.side  = in_side;
      for (int i = 0; i < 3; i++) begin
         sq_in.neg[i] = in_a[i][A_W-1];
         sq_in.mag[i] = mag_a($signed(in_a[i]));
         sq_in.sq[i]  = SQ_W'(sq_in.mag[i]) * SQ_W'(sq_in.mag[i]);
      end

      rt_in[0].valid = sq_ff.valid;
      rt_in[0].mag   = sq_ff.mag;
      rt_in[0].neg   = sq_ff.neg;
      rt_in[0].side  = sq_ff.side;
      rt_in[0].x     = {sq_ff.sq[0] + sq_ff.sq[1] + sq_ff.sq[2], 16'h0000};
      rt_in[0].rem   = '0;
      rt_in[0].root  = '0;

      for (int k = 1; k <= ROOT_W; k++) begin
         rt_in[k] = rt_ff[k-1];
         remn = {rt_ff[k-1].rem[ROOT_W-1:0], rt_ff[k-1].x[X_W-1 -: 2]};
         test = {rt_ff[k-1].root, 2'b01};
         rt_in[k].x = rt_ff[k-1].x << 2;
         if (remn >= test) begin
            rt_in[k].rem  = remn - test;
            rt_in[k].root = {rt_ff[k-1].root[ROOT_W-2:0], 1'b1};
         end else begin
            rt_in[k].rem  = remn;
            rt_in[k].root = {rt_ff[k-1].root[ROOT_W-2:0], 1'b0};
         end
      end

      len = rt_ff[ROOT_W].root;
      dv_in[0].valid = rt_ff[ROOT_W].valid;
      dv_in[0].neg   = rt_ff[ROOT_W].neg;
      dv_in[0].side  = rt_ff[ROOT_W].side;
      dv_in[0].d     = {len, 1'b0};
      dv_in[0].zero  = (len == '0);
      dv_in[0].q     = '0;
      for (int i = 0; i < 3; i++) begin
         dv_in[0].num[i] = NUM_W'({rt_ff[ROOT_W].mag[i], 23'h0}) + NUM_W'(len);
      end

      for (int k = 1; k <= Q_W; k++) begin
         dv_in[k] = dv_ff[k-1];
         dsh = NUM_W'(dv_ff[k-1].d) << (Q_W - k);
         for (int i = 0; i < 3; i++) begin
            if (dv_ff[k-1].num[i] >= dsh) begin
               dv_in[k].num[i]        = dv_ff[k-1].num[i] - dsh;
               dv_in[k].q[i][Q_W-k]   = 1'b1;
            end
         end
      end

      for (int i = 0; i < 3; i++) begin
         qv = dv_ff[Q_W].q[i];
         if (dv_ff[Q_W].zero) begin
            out_o_in[i] = '0;
         end else if (dv_ff[Q_W].neg[i]) begin
            out_o_in[i] = -NRM_W'(qv);
         end else begin
            out_o_in[i] = NRM_W'(qv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= ROOT_W; k++) begin
            rt_ff[k].valid <= 1'b0;
         end
         for (int k = 0; k <= Q_W; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         sq_ff        <= sq_in;
         out_valid_ff <= dv_ff[Q_W].valid;
         for (int k = 0; k <= ROOT_W; k++) begin
            rt_ff[k] <= rt_in[k];
         end
         for (int k = 0; k <= Q_W; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_o_ff    <= out_o_in;
         out_side_ff <= dv_ff[Q_W].side;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_o     = out_o_ff;
   assign out_side  = out_side_ff;

endmodule
`default_nettype wire

// File: rtl/pnei_back.sv
// pnei_back: builds n, u, v and the information matrix, holds the weight and the result queue
// depends on pnei_pkg and pnei_norm
`default_nettype none
module pnei_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [pnei_pkg::W_W-1:0] csr_wdata,
   input  logic                     mid_valid,
   output logic                     mid_pop,
   input  pnei_pkg::mid_type        mid_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output pnei_pkg::rsp_type        rsp_data
);
   import pnei_pkg::*;

   localparam int unsigned OAW = $clog2(OUTQ_DEPTH);
   localparam int unsigned OCW = $clog2(OUTQ_DEPTH + 1);
   localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
   localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

   logic [W_W-1:0]        weight_ff;
   logic                  adv;
   side_type              n1_side_in;
   logic                  n1_valid, n2_valid, n3_valid;
   logic [2:0][NRM_W-1:0] n1_o, n2_o, n3_o;
   side_type              n1_side, n2_side, n3_side;
   a_stage_type           sa_ff, sa_in;
   cp_stage_type          c1_ff, c1_in;
   a_stage_type           c2_ff, c2_in;
   p1_stage_type          p1_ff, p1_in;
   p2_stage_type          p2_ff, p2_in;
   p3_stage_type          p3_ff, p3_in;
   rsp_type               res;
   rsp_type               oq_ff [OUTQ_DEPTH];
   logic [OAW-1:0]        oh_ff, oh_in, ot_ff, ot_in;
   logic [OCW-1:0]        oc_ff, oc_in;
   logic                  oq_full;
   logic                  opush, opop;

   assign oq_full = (oc_ff == OCW'(OUTQ_DEPTH));
   assign adv     = !(p3_ff.valid && oq_full);
   assign mid_pop = adv && mid_valid;

   always_comb begin
      n1_side_in.err   = mid_data.err;
      n1_side_in.degen = mid_data.degen;
      n1_side_in.n     = '0;
      n1_side_in.u     = '0;
   end

   pnei_norm u_norm_n (
      .clock(clock), .reset(reset), .en(adv), .in_valid(mid_pop), .in_a(mid_data.sum),
      .in_side(n1_side_in), .out_valid(n1_valid), .out_o(n1_o), .out_side(n1_side)
   );

   always_comb begin
      logic [NRM_W-1:0] m0, m1, m2;
      m0 = mag_n($signed(n1_o[0]));
      m1 = mag_n($signed(n1_o[1]));
      m2 = mag_n($signed(n1_o[2]));
      sa_in.valid  = n1_valid;
      sa_in.side   = n1_side;
      sa_in.side.n = n1_o;
      if (m1 >= m0 && m1 >= m2) begin
         sa_in.a[0] = '0;
         sa_in.a[1] = -A_W'($signed(n1_o[2]));
         sa_in.a[2] = A_W'($signed(n1_o[1]));
      end else begin
         sa_in.a[0] = A_W'($signed(n1_o[2]));
         sa_in.a[1] = '0;
         sa_in.a[2] = -A_W'($signed(n1_o[0]));
      end
   end

   pnei_norm u_norm_u (
      .clock(clock), .reset(reset), .en(adv), .in_valid(sa_ff.valid), .in_a(sa_ff.a),
      .in_side(sa_ff.side), .out_valid(n2_valid), .out_o(n2_o), .out_side(n2_side)
   );

   always_comb begin
      logic signed [NRM_W-1:0] nx, ny, nz, ux, uy, uz;
      nx = $signed(n2_side.n[0]);
      ny = $signed(n2_side.n[1]);
      nz = $signed(n2_side.n[2]);
      ux = $signed(n2_o[0]);
      uy = $signed(n2_o[1]);
      uz = $signed(n2_o[2]);
      c1_in.valid  = n2_valid;
      c1_in.side   = n2_side;
      c1_in.side.u = n2_o;
      c1_in.p[0]   = ny * uz;
      c1_in.p[1]   = nz * uy;
      c1_in.p[2]   = nz * ux;
      c1_in.p[3]   = nx * uz;
      c1_in.p[4]   = nx * uy;
      c1_in.p[5]   = ny * ux;
   end

   always_comb begin
      c2_in.valid = c1_ff.valid;
      c2_in.side  = c1_ff.side;
      c2_in.a[0]  = rnd14($signed(c1_ff.p[0]), $signed(c1_ff.p[1]));
      c2_in.a[1]  = rnd14($signed(c1_ff.p[2]), $signed(c1_ff.p[3]));
      c2_in.a[2]  = rnd14($signed(c1_ff.p[4]), $signed(c1_ff.p[5]));
   end

   pnei_norm u_norm_v (
      .clock(clock), .reset(reset), .en(adv), .in_valid(c2_ff.valid), .in_a(c2_ff.a),
      .in_side(c2_ff.side), .out_valid(n3_valid), .out_o(n3_o), .out_side(n3_side)
   );

   always_comb begin
      logic [2:0][2:0][NRM_W-1:0] col;
      col[0] = n3_side.u;
      col[1] = n3_o;
      col[2] = n3_side.n;
      p1_in.valid = n3_valid;
      p1_in.err   = n3_side.err;
      p1_in.degen = n3_side.degen;
      for (int k = 0; k < 6; k++) begin
         for (int c = 0; c < 3; c++) begin
            p1_in.p[k][c] = $signed(col[PAIR_I[k]][c]) * $signed(col[PAIR_J[k]][c]);
         end
      end
   end

   always_comb begin
      p2_in.valid = p1_ff.valid;
      p2_in.err   = p1_ff.err;
      p2_in.degen = p1_ff.degen;
      for (int k = 0; k < 6; k++) begin
         p2_in.sxy[k] = (PROD_W+1)'($signed(p1_ff.p[k][0]))
                      + (PROD_W+1)'($signed(p1_ff.p[k][1]));
         p2_in.wz[k]  = WZ_W'($signed({1'b0, weight_ff}) * $signed(p1_ff.p[k][2]));
      end
   end

   always_comb begin
      p3_in.valid = p2_ff.valid;
      p3_in.err   = p2_ff.err;
      p3_in.degen = p2_ff.degen;
      for (int k = 0; k < 6; k++) begin
         p3_in.acc[k] = ACC_W'($signed(p2_ff.sxy[k])) + ACC_W'($signed(p2_ff.wz[k]));
      end
   end

   always_comb begin
      res.error_x    = p3_ff.err[0];
      res.error_y    = p3_ff.err[1];
      res.error_z    = p3_ff.err[2];
      res.degenerate = p3_ff.degen;
      if (p3_ff.degen) begin
         res.info_xx = INFO_ONE;
         res.info_xy = '0;
         res.info_xz = '0;
         res.info_yy = INFO_ONE;
         res.info_yz = '0;
         res.info_zz = INFO_ONE;
      end else begin
         res.info_xx = info_round($signed(p3_ff.acc[0]));
         res.info_xy = info_round($signed(p3_ff.acc[1]));
         res.info_xz = info_round($signed(p3_ff.acc[2]));
         res.info_yy = info_round($signed(p3_ff.acc[3]));
         res.info_yz = info_round($signed(p3_ff.acc[4]));
         res.info_zz = info_round($signed(p3_ff.acc[5]));
      end
   end

   assign opush     = adv && p3_ff.valid;
   assign opop      = rsp_pop && !rsp_empty;
   assign rsp_empty = (oc_ff == '0);
   assign rsp_data  = oq_ff[oh_ff];

   always_comb begin
      oh_in = opop ? oh_ff + OAW'(1) : oh_ff;
      ot_in = opush ? ot_ff + OAW'(1) : ot_ff;
      oc_in = oc_ff + OCW'(opush) - OCW'(opop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff   <= NORMAL_WEIGHT_RESET;
         sa_ff.valid <= 1'b0;
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         p1_ff.valid <= 1'b0;
         p2_ff.valid <= 1'b0;
         p3_ff.valid <= 1'b0;
         oh_ff       <= '0;
         ot_ff       <= '0;
         oc_ff       <= '0;
      end else begin
         if (csr_we) begin
            weight_ff <= csr_wdata;
         end
         if (adv) begin
            sa_ff <= sa_in;
            c1_ff <= c1_in;
            c2_ff <= c2_in;
            p1_ff <= p1_in;
            p2_ff <= p2_in;
            p3_ff <= p3_in;
         end
         oh_ff <= oh_in;
         ot_ff <= ot_in;
         oc_ff <= oc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         oq_ff[ot_ff] <= res;
      end
   end

`ifndef SYNTHESIS
   a_oq_count: assert property (@(posedge clock) disable iff (reset)
      oc_ff <= OCW'(OUTQ_DEPTH))
      else $error("result queue count out of range");

   a_degen_ident: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.degenerate) |->
      (rsp_data.info_xx == INFO_ONE && rsp_data.info_xy == '0 && rsp_data.info_zz == INFO_ONE))
      else $error("degenerate beat without identity matrix");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (p3_ff.valid && oq_full && !rsp_pop) |=> (p3_ff.valid && $stable(p3_ff.acc)))
      else $error("last stage lost while result queue full");

   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (opop && oc_ff == OCW'(1) && !opush) |=> rsp_empty)
      else $error("result queue not empty after last beat popped");
`endif

endmodule
`default_nettype wire

// File: rtl/point_normal_edge_error_information.sv
// point_normal_edge_error_information: top level, front classifier and back matrix pipeline
// depends on pnei_pkg, pnei_front and pnei_back
//
// usage:
//   req channel: drive req_data and raise req_push; a beat is taken at a clock edge
//   with req_push high and req_full low. one beat may be taken every cycle.
//   rsp channel: while rsp_empty is low the oldest result is on rsp_data; it is taken
//   at a clock edge with rsp_pop high. results leave in request order, one per request.
//   csr port: csr_we with csr_wdata writes the normal axis weight (reset value 100000).
//   write it only while no beats are in flight.
// throughput and path:
//   one beat per cycle sustained while rsp is popped. a taken beat passes the front
//   queue, three normalize units (square sum, 26 root stages, 16 divide stages, output
//   register), plus axis, cross product and matrix stages and the result queue.
// reset: synchronous; empties both queues and the pipeline, restores the weight.
// stall: when rsp is not popped the result queue fills and the back pipeline holds;
//   the 4-deep front queue then fills and req_full rises. nothing is dropped.
`default_nettype none
module point_normal_edge_error_information (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  pnei_pkg::req_type        req_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output pnei_pkg::rsp_type        rsp_data,
   input  logic                     csr_we,
   input  logic [pnei_pkg::W_W-1:0] csr_wdata
);
   import pnei_pkg::*;

   logic    mid_valid;
   logic    mid_pop;
   mid_type mid_data;

   pnei_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .mid_valid(mid_valid), .mid_pop(mid_pop), .mid_data(mid_data)
   );

   pnei_back u_back (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .mid_valid(mid_valid), .mid_pop(mid_pop), .mid_data(mid_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

// File: test/testbench.sv
// testbench for point_normal_edge_error_information: directed and random edge beats,
// weight changes while idle, back pressure; results checked against a local predictor
// depends on pnei_pkg and the rtl top level
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import pnei_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES   = 300;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   req_type            req_data;
   logic               rsp_empty;
   logic               rsp_pop;
   rsp_type            rsp_data;
   logic               csr_we;
   logic [W_W-1:0]     csr_wdata;

   rsp_type            pending_results[$];
   longint unsigned    weight_model;
   int                 error_count;
   int                 hold_request;
   int                 hold_left;
   int                 pop_gap_left;
   int                 idle_cycles;
   bit                 req_taken;

   point_normal_edge_error_information DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint sat_32(input longint x);
      if (x > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return x;
   endfunction

   function automatic longint round_away(input longint x, input int sh);
      longint unsigned m;
      longint unsigned r;
      m = (x < 0) ? longint'(-x) : x;
      r = (m + (64'd1 << (sh - 1))) >> sh;
      return (x < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic void unit_vector(input longint a[3], output longint o[3]);
      longint unsigned s;
      longint unsigned len;
      longint unsigned m;
      longint unsigned q;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m = (a[i] < 0) ? longint'(-a[i]) : a[i];
         s += m * m;
      end
      len = int_sqrt(s << 16);
      for (int i = 0; i < 3; i++) begin
         m = (a[i] < 0) ? longint'(-a[i]) : a[i];
         if (len == 0) begin
            o[i] = 0;
         end else begin
            q = ((m << 23) + len) / (2 * len);
            o[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
         end
      end
   endfunction

   function automatic longint abs_of(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic rsp_type predict_edge(input req_type r);
      rsp_type        e;
      longint         s[3];
      longint         n[3];
      longint         a[3];
      longint         u[3];
      longint         v[3];
      longint         c[3][3];
      longint         info[6];
      longint         acc;
      longint unsigned sq;
      int             k;
      e.error_x = 32'(sat_32(longint'(r.first_point_x) - longint'(r.second_point_x)));
      e.error_y = 32'(sat_32(longint'(r.first_point_y) - longint'(r.second_point_y)));
      e.error_z = 32'(sat_32(longint'(r.first_point_z) - longint'(r.second_point_z)));
      s[0] = longint'(r.first_normal_x) + longint'(r.second_normal_x);
      s[1] = longint'(r.first_normal_y) + longint'(r.second_normal_y);
      s[2] = longint'(r.first_normal_z) + longint'(r.second_normal_z);
      sq = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
      if (sq == 0) begin
         e.info_xx = INFO_ONE;
         e.info_xy = 0;
         e.info_xz = 0;
         e.info_yy = INFO_ONE;
         e.info_yz = 0;
         e.info_zz = INFO_ONE;
         e.degenerate = 1'b1;
         return e;
      end
      unit_vector(s, n);
      if (abs_of(n[1]) >= abs_of(n[0]) && abs_of(n[1]) >= abs_of(n[2])) begin
         a[0] = 0;
         a[1] = -n[2];
         a[2] = n[1];
      end else begin
         a[0] = n[2];
         a[1] = 0;
         a[2] = -n[0];
      end
      unit_vector(a, u);
      a[0] = round_away(n[1] * u[2] - n[2] * u[1], 14);
      a[1] = round_away(n[2] * u[0] - n[0] * u[2], 14);
      a[2] = round_away(n[0] * u[1] - n[1] * u[0], 14);
      unit_vector(a, v);
      c[0] = u;
      c[1] = v;
      c[2] = n;
      k = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = i; j < 3; j++) begin
            acc = c[i][0] * c[j][0] + c[i][1] * c[j][1]
                + longint'(weight_model) * (c[i][2] * c[j][2]);
            info[k] = sat_32(round_away(acc, 18));
            k++;
         end
      end
      e.info_xx = 32'(info[0]);
      e.info_xy = 32'(info[1]);
      e.info_xz = 32'(info[2]);
      e.info_yy = 32'(info[3]);
      e.info_yz = 32'(info[4]);
      e.info_zz = 32'(info[5]);
      e.degenerate = 1'b0;
      return e;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   task automatic compare_beat(input rsp_type got, input rsp_type want);
      if (got.error_x !== want.error_x) report_mismatch("error_x", got.error_x, want.error_x);
      if (got.error_y !== want.error_y) report_mismatch("error_y", got.error_y, want.error_y);
      if (got.error_z !== want.error_z) report_mismatch("error_z", got.error_z, want.error_z);
      if (got.info_xx !== want.info_xx) report_mismatch("info_xx", got.info_xx, want.info_xx);
      if (got.info_xy !== want.info_xy) report_mismatch("info_xy", got.info_xy, want.info_xy);
      if (got.info_xz !== want.info_xz) report_mismatch("info_xz", got.info_xz, want.info_xz);
      if (got.info_yy !== want.info_yy) report_mismatch("info_yy", got.info_yy, want.info_yy);
      if (got.info_yz !== want.info_yz) report_mismatch("info_yz", got.info_yz, want.info_yz);
      if (got.info_zz !== want.info_zz) report_mismatch("info_zz", got.info_zz, want.info_zz);
      if (got.degenerate !== want.degenerate) begin
         report_mismatch("degenerate", got.degenerate, want.degenerate);
      end
   endtask

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // result side: check popped beats, drive pop with random gaps and long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $display("unexpected result beat at %0t", $realtime);
               error_count++;
            end else begin
               compare_beat(rsp_data, pending_results.pop_front());
            end
         end
         if ((rsp_pop && !rsp_empty) || req_taken) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("point_normal_edge_error_information verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_gap_left > 0) begin
            pop_gap_left--;
            rsp_pop <= 1'b0;
         end else begin
            pop_gap_left = random_gap();
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send_beat(input req_type item, input bit spaced);
      int gap;
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      req_taken = 1'b1;
      pending_results.push_back(predict_edge(item));
      gap = spaced ? random_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) begin
            @(posedge clock);
            req_taken = 1'b0;
         end
      end else begin
         // next beat follows without dropping push
         #1 req_taken = 1'b0;
      end
   endtask

   task automatic wait_all_results();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_weight(input logic [W_W-1:0] value);
      wait_all_results();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      weight_model = value;
   endtask

   function automatic logic signed [15:0] random_normal_part(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 32768)) - 16384);
         default: return 16'($signed($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   function automatic logic signed [31:0] random_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 32'sh7fff_ffff;
      if (pick == 1) return 32'sh8000_0000;
      if (pick < 6) return 32'($urandom);
      return 32'($signed($urandom_range(0, 2000000)) - 1000000);
   endfunction

   function automatic req_type random_edge();
      req_type r;
      int      mode;
      int      shape;
      mode = $urandom_range(0, 2);
      shape = $urandom_range(0, 19);
      r.first_point_x = random_coord();
      r.first_point_y = random_coord();
      r.first_point_z = random_coord();
      r.second_point_x = random_coord();
      r.second_point_y = random_coord();
      r.second_point_z = random_coord();
      r.first_normal_x = random_normal_part(mode);
      r.first_normal_y = random_normal_part(mode);
      r.first_normal_z = random_normal_part(mode);
      r.second_normal_x = random_normal_part(mode);
      r.second_normal_y = random_normal_part(mode);
      r.second_normal_z = random_normal_part(mode);
      if (shape == 0) begin
         // opposite normals cancel
         r.second_normal_x = -r.first_normal_x;
         r.second_normal_y = -r.first_normal_y;
         r.second_normal_z = -r.first_normal_z;
      end else if (shape == 1) begin
         // y magnitude ties the x magnitude
         r.second_normal_x = r.first_normal_x;
         r.second_normal_y = r.first_normal_x;
         r.second_normal_z = r.first_normal_z;
         r.first_normal_y = r.first_normal_x;
      end else if (shape == 2) begin
         r.second_normal_x = r.first_normal_x;
         r.second_normal_y = r.first_normal_y;
         r.second_normal_z = r.first_normal_z;
      end
      return r;
   endfunction

   function automatic req_type make_edge(input logic signed [31:0] p1, input logic signed [31:0] p2,
                                         input logic signed [15:0] nx, input logic signed [15:0] ny,
                                         input logic signed [15:0] nz, input logic signed [15:0] mx,
                                         input logic signed [15:0] my, input logic signed [15:0] mz);
      req_type r;
      r.first_point_x = p1;
      r.first_point_y = p2;
      r.first_point_z = p1;
      r.second_point_x = p2;
      r.second_point_y = p1;
      r.second_point_z = -p2;
      r.first_normal_x = nx;
      r.first_normal_y = ny;
      r.first_normal_z = nz;
      r.second_normal_x = mx;
      r.second_normal_y = my;
      r.second_normal_z = mz;
      return r;
   endfunction

   task automatic test_directed();
      send_beat(make_edge(32'sh7fff_ffff, 32'sh8000_0000, 16384, 0, 0, 16384, 0, 0), 1);
      send_beat(make_edge(32'sh8000_0000, 32'sh7fff_ffff, 0, 16384, 0, 0, 16384, 0), 1);
      send_beat(make_edge(0, 0, 0, 0, 16384, 0, 0, 16384), 1);
      send_beat(make_edge(65536, -65536, 0, 0, 0, 0, 0, 0), 1);
      send_beat(make_edge(1, 1, 100, -200, 300, -100, 200, -300), 1);
      send_beat(make_edge(-1, 5, 16384, 16384, 0, 0, 0, 0), 1);
      send_beat(make_edge(7, 3, 0, 16384, 16384, 0, 0, 0), 1);
      send_beat(make_edge(7, 3, 1000, -1000, 1000, 0, 0, 0), 1);
      send_beat(make_edge(7, 3, 16384, 16383, 0, 0, 0, 0), 1);
      send_beat(make_edge(0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                          16'sh8000), 1);
      send_beat(make_edge(0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                          16'sh7fff), 1);
      send_beat(make_edge(0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0, 0), 1);
      send_beat(make_edge(0, 0, 1, 0, 0, 0, 0, 0), 1);
      send_beat(make_edge(0, 0, 0, -1, 0, 0, 0, 0), 1);
      send_beat(make_edge(0, 0, 0, 0, -1, 0, 0, 0), 1);
      send_beat(make_edge(0, 0, -16384, 0, 0, 0, 0, 0), 1);
      send_beat(make_edge(0, 0, 0, 0, -16384, 0, 0, 0), 1);
      send_beat(make_edge(32'sh4000_0000, 32'shc000_0000, 11585, 0, 11585, 0, 0, 0), 1);
   endtask

   task automatic test_weights();
      logic [W_W-1:0] settings[5];
      settings = '{20'd1, 20'hfffff, 20'd0, 20'd1024, 20'd54321};
      foreach (settings[i]) begin
         write_weight(settings[i]);
         test_directed();
         repeat (60) send_beat(random_edge(), 1);
      end
   endtask

   task automatic test_random();
      write_weight(NORMAL_WEIGHT_RESET);
      repeat (700) send_beat(random_edge(), 1);
      write_weight(W_W'($urandom_range(1, 1048575)));
      repeat (400) send_beat(random_edge(), 1);
   endtask

   task automatic test_backpressure();
      wait_all_results();
      hold_request = 600;
      repeat (250) send_beat(random_edge(), 0);
   endtask

   initial begin
      error_count = 0;
      hold_request = 0;
      hold_left = 0;
      pop_gap_left = 0;
      req_taken = 1'b0;
      weight_model = NORMAL_WEIGHT_RESET;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_weights();
      test_random();
      test_backpressure();
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0d result beats never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("point_normal_edge_error_information verification clean");
      end else begin
         $display("point_normal_edge_error_information verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
